// File: rtl/two_level_writeback_cache_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-level write-back cache core
// Concurrent checks that can be removed from a build with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_WRITEBACK_CACHE_CORE_ASSERT_SVH
`define TWO_LEVEL_WRITEBACK_CACHE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TWC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed");
`define TWC_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define TWC_ASSERT(lbl, clk, rst_n, prop)
`define TWC_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: rtl/twc_pkg.sv
// ----------------------------------------------------------------------------
// Two-level write-back cache package
// Address split, widths and the per-set tag and state record.
// ----------------------------------------------------------------------------
package twc_pkg;

  localparam int WIDX_W  = 4;   // word within a block
  localparam int LINE_W  = 8;   // L1 line and L2 set
  localparam int TAG_W   = 6;
  localparam int BLK_W   = TAG_W + LINE_W;
  localparam int DADDR_W = BLK_W + WIDX_W;
  localparam int L1A_W   = LINE_W + WIDX_W;
  localparam int L2A_W   = LINE_W + 1 + WIDX_W;
  localparam int DATA_W  = 32;
  localparam int COST_W  = 13;
  localparam int CFG_W   = 10;
  localparam int CFGA_W  = 3;
  localparam int BLOCK_WORDS = 1 << WIDX_W;
  localparam int SETS        = 1 << LINE_W;
  localparam int DBLOCKS     = 1 << BLK_W;

  localparam int IN_W  = 56;
  localparam int OUT_W = 80;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } way_meta_t;

  typedef struct packed {
    way_meta_t       l1;
    way_meta_t [1:0] l2;
    logic            recent;
  } set_meta_t;

  localparam int META_W = $bits(set_meta_t);

endpackage

// File: rtl/twc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module twc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: rtl/two_level_writeback_cache_core.sv
// ----------------------------------------------------------------------------
// Two-level write-back cache core
// Direct-mapped L1 and two-way L2 with a zeroed DRAM store behind them.
//
//   channel | dir | handshake         | payload
//   in_     | in  | in_tvalid/tready  | in_tdata: op, address, write_data
//   out_    | out | out_tvalid/tready | out_tdata: read_data, access_cost,
//           |     |                   |   total_time
//   cfg_    | in  | cfg_we            | cfg_addr, cfg_wdata
//
// A read hit runs from accept through S_LOOK, S_WORD, S_RD and S_DONE and a
// write hit through S_LOOK, S_WORD and S_DONE; the next word is taken back in
// S_IDLE. Each block transfer runs through the memories one word a cycle; a
// miss adds two to seven such transfers plus control states. After reset a
// clearing pass runs over all 16384 DRAM block flags and the tag store before
// the first word is taken. A stalled result holds the block in S_DONE.
// ----------------------------------------------------------------------------
`include "two_level_writeback_cache_core_assert.svh"

module two_level_writeback_cache_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // op, address, write_data, zero fill
  input  logic [twc_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // read_data, access_cost, total_time
  output logic [twc_pkg::OUT_W-1:0]    out_tdata,
  input  logic                         cfg_we,
  input  logic [twc_pkg::CFGA_W-1:0]   cfg_addr,
  input  logic [twc_pkg::CFG_W-1:0]    cfg_wdata
);
  import twc_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOOK, S_L2, S_FILL2, S_XFER, S_VICT, S_BUFL1,
    S_COPY, S_WORD, S_RD, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    CP_L2_DRAM, CP_DRAM_L2, CP_L2_BUF, CP_L1_L2, CP_BUF_L1
  } copy_t;

  typedef enum logic [CFGA_W-1:0] {
    R_DRAM_RD, R_DRAM_WR, R_L1_RD, R_L1_WR, R_L2_RD, R_L2_WR
  } reg_idx_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  copy_t cp_r, cp_nxt;
  logic [BLK_W:0] clr_r, clr_nxt;
  logic op_r, op_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [WIDX_W-1:0] word_r, word_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt, l2tag_r, l2tag_nxt, dtag_r, dtag_nxt;
  logic [DATA_W-1:0] wdata_r, wdata_nxt, rdata_r, rdata_nxt;
  set_meta_t meta_r, meta_nxt;
  logic [COST_W-1:0] cost_r, cost_nxt;
  logic [DATA_W-1:0] total_r, total_nxt;
  logic phase_r, phase_nxt, way_r, way_nxt;
  logic [WIDX_W:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_rdata_r, out_rdata_nxt, out_total_r, out_total_nxt;
  logic [COST_W-1:0] out_cost_r, out_cost_nxt;
  logic [CFG_W-1:0] dram_rd_r, dram_wr_r, l1_rd_r, l1_wr_r, l2_rd_r, l2_wr_r;

  logic hit0, hit1, vw;
  logic copying, cwr;
  logic [WIDX_W-1:0] widx;
  logic [DATA_W-1:0] src_data, dram_q;

  logic l1_we, l2_we, dram_we, buf_we, flag_we, flag_wdata, flag_q, meta_we;
  logic [L1A_W-1:0] l1_waddr, l1_raddr;
  logic [L2A_W-1:0] l2_waddr, l2_raddr;
  logic [DADDR_W-1:0] dram_waddr, dram_raddr;
  logic [BLK_W-1:0] flag_waddr, flag_raddr;
  logic [LINE_W-1:0] meta_waddr;
  logic [DATA_W-1:0] l1_wdata, l1_q, l2_q, buf_q, dram_rd;
  set_meta_t meta_wdata, meta_q;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, {(16 - COST_W){1'b0}}, out_cost_r, out_rdata_r};

  assign copying = (state_r == S_COPY);
  assign cwr     = copying && (cnt_r != '0);
  assign widx    = WIDX_W'(cnt_r - 1'b1);
  assign dram_q  = flag_q ? dram_rd : '0;

  assign hit0 = meta_r.l2[0].valid && (meta_r.l2[0].tag == l2tag_r);
  assign hit1 = meta_r.l2[1].valid && (meta_r.l2[1].tag == l2tag_r);
  assign vw   = !meta_r.l2[0].valid ? 1'b0 :
                (!meta_r.l2[1].valid ? 1'b1 : ~meta_r.recent);

  always_comb begin
    case (cp_r)
      CP_DRAM_L2: src_data = dram_q;
      CP_L1_L2:   src_data = l1_q;
      CP_BUF_L1:  src_data = buf_q;
      default:    src_data = l2_q;
    endcase
  end

  // Memory ports.
  assign l1_raddr   = copying ? {line_r, cnt_r[WIDX_W-1:0]} : {line_r, word_r};
  assign l2_raddr   = {line_r, way_r, cnt_r[WIDX_W-1:0]};
  assign dram_raddr = {dtag_r, line_r, cnt_r[WIDX_W-1:0]};
  assign flag_raddr = {dtag_r, line_r};
  assign l2_we      = cwr && (cp_r == CP_DRAM_L2 || cp_r == CP_L1_L2);
  assign l2_waddr   = {line_r, way_r, widx};
  assign dram_we    = cwr && (cp_r == CP_L2_DRAM);
  assign dram_waddr = {dtag_r, line_r, widx};
  assign buf_we     = cwr && (cp_r == CP_L2_BUF);
  assign l1_we      = (cwr && cp_r == CP_BUF_L1) || (state_r == S_WORD && op_r);
  assign l1_waddr   = copying ? {line_r, widx} : {line_r, word_r};
  assign l1_wdata   = copying ? src_data : wdata_r;
  assign flag_we    = (state_r == S_CLR) || dram_we;
  assign flag_waddr = (state_r == S_CLR) ? clr_r[BLK_W-1:0] : {dtag_r, line_r};
  assign flag_wdata = (state_r != S_CLR);
  assign meta_we    = (state_r == S_CLR && clr_r[BLK_W:LINE_W] == '0) ||
                      (state_r == S_DONE && (!out_valid_r || out_tready));
  assign meta_waddr = (state_r == S_CLR) ? clr_r[LINE_W-1:0] : line_r;
  assign meta_wdata = (state_r == S_CLR) ? '0 : meta_r;

  twc_ram #(.WIDTH(DATA_W), .DEPTH(SETS * BLOCK_WORDS)) u_l1_words (
    .clk(clk), .we(l1_we), .waddr(l1_waddr), .wdata(l1_wdata),
    .raddr(l1_raddr), .rdata(l1_q));

  twc_ram #(.WIDTH(DATA_W), .DEPTH(2 * SETS * BLOCK_WORDS)) u_l2_words (
    .clk(clk), .we(l2_we), .waddr(l2_waddr), .wdata(src_data),
    .raddr(l2_raddr), .rdata(l2_q));

  twc_ram #(.WIDTH(DATA_W), .DEPTH(DBLOCKS * BLOCK_WORDS)) u_dram (
    .clk(clk), .we(dram_we), .waddr(dram_waddr), .wdata(src_data),
    .raddr(dram_raddr), .rdata(dram_rd));

  twc_ram #(.WIDTH(1), .DEPTH(DBLOCKS)) u_dram_flag (
    .clk(clk), .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
    .raddr(flag_raddr), .rdata(flag_q));

  twc_ram #(.WIDTH(DATA_W), .DEPTH(BLOCK_WORDS)) u_fill_buf (
    .clk(clk), .we(buf_we), .waddr(widx), .wdata(src_data),
    .raddr(cnt_r[WIDX_W-1:0]), .rdata(buf_q));

  twc_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(in_tdata[14:7]), .rdata(meta_q));

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    cp_nxt = cp_r;
    clr_nxt = clr_r;
    op_nxt = op_r;
    line_nxt = line_r;
    word_nxt = word_r;
    tag_nxt = tag_r;
    wdata_nxt = wdata_r;
    l2tag_nxt = l2tag_r;
    dtag_nxt = dtag_r;
    rdata_nxt = rdata_r;
    meta_nxt = meta_r;
    cost_nxt = cost_r;
    total_nxt = total_r;
    phase_nxt = phase_r;
    way_nxt = way_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_rdata_nxt = out_rdata_r;
    out_cost_nxt = out_cost_r;
    out_total_nxt = out_total_r;
    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (BLK_W + 1)'(DBLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = in_tdata[0];
          word_nxt = in_tdata[6:3];
          line_nxt = in_tdata[14:7];
          tag_nxt = in_tdata[20:15];
          wdata_nxt = in_tdata[52:21];
          cost_nxt = '0;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        meta_nxt = meta_q;
        if (meta_q.l1.valid && meta_q.l1.tag == tag_r) begin
          state_nxt = S_WORD;
        end else begin
          phase_nxt = 1'b0;
          l2tag_nxt = tag_r;
          state_nxt = S_L2;
        end
      end
      S_L2: begin
        if (hit0 || hit1) begin
          way_nxt = hit1 && !hit0;
          state_nxt = S_XFER;
        end else begin
          way_nxt = vw;
          meta_nxt.l2[vw] = '{valid: 1'b1, dirty: 1'b0, tag: l2tag_r};
          if (meta_r.l2[vw].valid && meta_r.l2[vw].dirty) begin
            cost_nxt = cost_r + COST_W'(dram_rd_r) + COST_W'(dram_wr_r);
            dtag_nxt = meta_r.l2[vw].tag;
            cp_nxt = CP_L2_DRAM;
            ret_nxt = S_FILL2;
            cnt_nxt = '0;
            state_nxt = S_COPY;
          end else begin
            cost_nxt = cost_r + COST_W'(dram_rd_r);
            state_nxt = S_FILL2;
          end
        end
      end
      S_FILL2: begin
        dtag_nxt = l2tag_r;
        cp_nxt = CP_DRAM_L2;
        ret_nxt = S_XFER;
        cnt_nxt = '0;
        state_nxt = S_COPY;
      end
      S_XFER: begin
        meta_nxt.recent = way_r;
        cnt_nxt = '0;
        state_nxt = S_COPY;
        if (!phase_r) begin
          cp_nxt = CP_L2_BUF;
          cost_nxt = cost_r + COST_W'(l2_rd_r);
          ret_nxt = S_VICT;
        end else begin
          cp_nxt = CP_L1_L2;
          meta_nxt.l2[way_r].dirty = 1'b1;
          cost_nxt = cost_r + COST_W'(l2_wr_r);
          ret_nxt = S_BUFL1;
        end
      end
      S_VICT: begin
        if (meta_r.l1.valid && meta_r.l1.dirty) begin
          phase_nxt = 1'b1;
          l2tag_nxt = meta_r.l1.tag;
          state_nxt = S_L2;
        end else begin
          state_nxt = S_BUFL1;
        end
      end
      S_BUFL1: begin
        meta_nxt.l1 = '{valid: 1'b1, dirty: 1'b0, tag: tag_r};
        cp_nxt = CP_BUF_L1;
        ret_nxt = S_WORD;
        cnt_nxt = '0;
        state_nxt = S_COPY;
      end
      S_COPY: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (WIDX_W + 1)'(BLOCK_WORDS)) begin
          state_nxt = ret_r;
        end
      end
      S_WORD: begin
        if (op_r) begin
          meta_nxt.l1.dirty = 1'b1;
          cost_nxt = cost_r + COST_W'(l1_wr_r);
          rdata_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          cost_nxt = cost_r + COST_W'(l1_rd_r);
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        rdata_nxt = l1_q;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          total_nxt = total_r + DATA_W'(cost_r);
          out_valid_nxt = 1'b1;
          out_rdata_nxt = rdata_r;
          out_cost_nxt = cost_r;
          out_total_nxt = total_r + DATA_W'(cost_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      cnt_r <= '0;
      total_r <= '0;
      out_valid_r <= 1'b0;
      dram_rd_r <= CFG_W'(100);
      dram_wr_r <= CFG_W'(50);
      l1_rd_r <= CFG_W'(1);
      l1_wr_r <= CFG_W'(1);
      l2_rd_r <= CFG_W'(10);
      l2_wr_r <= CFG_W'(5);
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      cnt_r <= cnt_nxt;
      total_r <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          R_DRAM_RD: dram_rd_r <= cfg_wdata;
          R_DRAM_WR: dram_wr_r <= cfg_wdata;
          R_L1_RD:   l1_rd_r <= cfg_wdata;
          R_L1_WR:   l1_wr_r <= cfg_wdata;
          R_L2_RD:   l2_rd_r <= cfg_wdata;
          R_L2_WR:   l2_wr_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    ret_r <= ret_nxt;
    cp_r <= cp_nxt;
    op_r <= op_nxt;
    line_r <= line_nxt;
    word_r <= word_nxt;
    tag_r <= tag_nxt;
    wdata_r <= wdata_nxt;
    l2tag_r <= l2tag_nxt;
    dtag_r <= dtag_nxt;
    rdata_r <= rdata_nxt;
    meta_r <= meta_nxt;
    cost_r <= cost_nxt;
    phase_r <= phase_nxt;
    way_r <= way_nxt;
    out_rdata_r <= out_rdata_nxt;
    out_cost_r <= out_cost_nxt;
    out_total_r <= out_total_nxt;
  end

  `TWC_ASSERT(a_result_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_DONE))
  `TWC_ASSERT(a_accept_looks_up, clk, rst_n, (in_tvalid && in_tready) |=> state_r == S_LOOK)
  `TWC_ASSERT(a_copy_count, clk, rst_n, copying |-> cnt_r <= (WIDX_W + 1)'(BLOCK_WORDS))
  `TWC_NEVER(a_no_idle_l1_write, clk, rst_n, l1_we && state_r == S_IDLE)

endmodule
